>>> rtl/core/fmes_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package fmes_pkg;

	// sizes
	localparam int SONG_BYTES_DEF = 16384;
	localparam int CHANNELS       = 11;
	localparam int PTR_W          = 15;
	localparam int CFG_W          = 15;
	localparam int STEP_W         = 5;

	// actions of an input item
	localparam logic [2:0] ACT_LOAD  = 3'd0;
	localparam logic [2:0] ACT_START = 3'd1;
	localparam logic [2:0] ACT_STOP  = 3'd2;
	localparam logic [2:0] ACT_TICK  = 3'd3;
	localparam logic [2:0] ACT_CONT  = 3'd4;

	// configuration register indexes
	localparam logic CFG_INSTR_COUNT = 1'b0;
	localparam logic CFG_SONG_LEN    = 1'b1;

	// event opcodes
	localparam logic [2:0] OP_DELAY  = 3'd0;
	localparam logic [2:0] OP_PATCH  = 3'd1;
	localparam logic [2:0] OP_NOTE   = 3'd2;
	localparam logic [2:0] OP_KEYOFF = 3'd3;
	localparam logic [2:0] OP_LEVEL  = 3'd4;
	localparam logic [2:0] OP_JUMP   = 3'd5;
	localparam logic [2:0] OP_MARK   = 3'd6;
	localparam logic [2:0] OP_NOP    = 3'd7;

	// write sequences
	localparam logic [2:0] SEQ_SILENCE = 3'd0;
	localparam logic [2:0] SEQ_PATCH   = 3'd1;
	localparam logic [2:0] SEQ_NOTE    = 3'd2;
	localparam logic [2:0] SEQ_KEYOFF  = 3'd3;
	localparam logic [2:0] SEQ_LEVEL   = 3'd4;
	localparam logic [2:0] SEQ_NONE    = 3'd5;

	// song memory read address select
	localparam logic [1:0] RD_EP0  = 2'd0;
	localparam logic [1:0] RD_EP1  = 2'd1;
	localparam logic [1:0] RD_STEP = 2'd2;
	localparam logic [1:0] RD_FLAG = 2'd3;

	// chip register constants
	localparam logic [4:0] SILENCE_WRITES = 5'd30;
	localparam logic [7:0] RHYTHM_REG     = 8'hbd;
	localparam logic [7:0] RHYTHM_INIT    = 8'he0;
	localparam logic [7:0] ATTEN_MAX      = 8'h3f;
	localparam logic [7:0] KEY_BASE       = 8'hb0;
	localparam logic [7:0] FNUM_BASE      = 8'ha0;
	localparam logic [7:0] LEVEL_BASE     = 8'h40;
	localparam logic [7:0] FB_BASE        = 8'hc0;
	localparam logic [7:0] RHY_TOP_BIT    = 8'h10;
	localparam logic [7:0] KEYON_BIT      = 8'h20;
	localparam logic [7:0] NOSLOT         = 8'hff;

	typedef struct packed {
		logic              take;
		logic              load;
		logic              start;
		logic              stop;
		logic              dly_dec;
		logic [1:0]        rd_sel;
		logic              cap0;
		logic              decode;
		logic              cap_flag;
		logic              emit;
		logic              emit_empty;
		logic              last;
		logic [STEP_W-1:0] step;
	} fmes_cmd_t;

	typedef struct packed {
		logic              playing;
		logic              delay_zero;
		logic              ep_ok;
		logic              seq_level;
		logic              n_zero;
		logic              step_mem;
		logic              out_free;
		logic [STEP_W-1:0] n;
	} fmes_sts_t;

	function automatic logic [7:0] mod_slot(input logic [3:0] ch);
		case (ch)
			4'd0: mod_slot = 8'h00;
			4'd1: mod_slot = 8'h01;
			4'd2: mod_slot = 8'h02;
			4'd3: mod_slot = 8'h08;
			4'd4: mod_slot = 8'h09;
			4'd5: mod_slot = 8'h0a;
			4'd6: mod_slot = 8'h10;
			4'd7: mod_slot = 8'h14;
			4'd8: mod_slot = 8'h12;
			4'd9: mod_slot = 8'h15;
			default: mod_slot = 8'h11;
		endcase
	endfunction

	function automatic logic [7:0] car_slot(input logic [3:0] ch);
		case (ch)
			4'd0: car_slot = 8'h03;
			4'd1: car_slot = 8'h04;
			4'd2: car_slot = 8'h05;
			4'd3: car_slot = 8'h0b;
			4'd4: car_slot = 8'h0c;
			4'd5: car_slot = 8'h0d;
			4'd6: car_slot = 8'h13;
			default: car_slot = NOSLOT;
		endcase
	endfunction

	function automatic logic [7:0] fb_index(input logic [3:0] ch);
		case (ch)
			4'd0: fb_index = 8'h00;
			4'd1: fb_index = 8'h01;
			4'd2: fb_index = 8'h02;
			4'd3: fb_index = 8'h03;
			4'd4: fb_index = 8'h04;
			4'd5: fb_index = 8'h05;
			4'd6: fb_index = 8'h06;
			4'd7: fb_index = 8'h07;
			4'd9: fb_index = 8'h08;
			default: fb_index = NOSLOT;
		endcase
	endfunction

	function automatic logic [7:0] grp_base(input logic [3:0] b);
		case (b)
			4'd0, 4'd5: grp_base = 8'h20;
			4'd1, 4'd6: grp_base = 8'h40;
			4'd2, 4'd7: grp_base = 8'h60;
			4'd3, 4'd8: grp_base = 8'h80;
			default: grp_base = 8'he0;
		endcase
	endfunction

	function automatic logic [7:0] atten_add(input logic [4:0] vol);
		case (vol)
			5'd0: atten_add = 8'h3f;
			5'd1: atten_add = 8'h14;
			5'd2: atten_add = 8'h10;
			5'd3: atten_add = 8'h0e;
			5'd4: atten_add = 8'h0c;
			5'd5: atten_add = 8'h0a;
			5'd6: atten_add = 8'h09;
			5'd7: atten_add = 8'h08;
			5'd8: atten_add = 8'h07;
			5'd9, 5'd10: atten_add = 8'h06;
			5'd11, 5'd12: atten_add = 8'h05;
			5'd13, 5'd14, 5'd15, 5'd16, 5'd17: atten_add = 8'h04;
			5'd18, 5'd19, 5'd20, 5'd21: atten_add = 8'h03;
			5'd22, 5'd23, 5'd24: atten_add = 8'h02;
			5'd25, 5'd26, 5'd27, 5'd28: atten_add = 8'h01;
			default: atten_add = 8'h00;
		endcase
	endfunction

	function automatic logic [7:0] freq_low(input logic [3:0] semi);
		case (semi)
			4'd0: freq_low = 8'hac;
			4'd1: freq_low = 8'hb6;
			4'd2: freq_low = 8'hc1;
			4'd3: freq_low = 8'hcd;
			4'd4: freq_low = 8'hd9;
			4'd5: freq_low = 8'he6;
			4'd6: freq_low = 8'hf3;
			4'd7: freq_low = 8'h02;
			4'd8: freq_low = 8'h11;
			4'd9: freq_low = 8'h22;
			4'd10: freq_low = 8'h33;
			default: freq_low = 8'h45;
		endcase
	endfunction

endpackage
`default_nettype wire

>>> rtl/core/fmes_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module fmes_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16384,
	localparam int AW = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// one write and one registered read a cycle
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

>>> rtl/core/fmes_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
module fmes_datapath import fmes_pkg::*; #(
	parameter int SONG_BYTES = SONG_BYTES_DEF
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire fmes_cmd_t        cmd,
	output fmes_sts_t             sts,
	input  wire logic [13:0]      address,
	input  wire logic [7:0]       data,
	input  wire logic             cfg_we,
	input  wire logic             cfg_index,
	input  wire logic [CFG_W-1:0] cfg_data,
	input  wire logic             out_ready,
	output logic                  out_valid,
	output logic                  write_valid,
	output logic      [7:0]       reg_addr,
	output logic      [7:0]       reg_value,
	output logic                  more,
	output logic                  last
);

	localparam int AW = $clog2(SONG_BYTES);

	function automatic logic [7:0] scaled(input logic [7:0] v, input logic [4:0] vol);
		logic [7:0] step_add;
		logic [6:0] att;
		step_add = atten_add(vol);
		att = {1'b0, v[5:0]} + step_add[6:0];
		scaled = (att > 7'h3f) ? {v[7:6], 6'h3f} : {v[7:6], att[5:0]};
	endfunction

	logic [9:0]        icount_q;
	logic [14:0]       slen_q;
	logic [PTR_W-1:0]  ep_q, lp_q;
	logic [7:0]        delay_q, rhythm_q;
	logic [7:0]        ci_q [CHANNELS];
	logic              playing_q;
	logic [2:0]        seq_q;
	logic [3:0]        ch_q;
	logic [7:0]        param_q;
	logic [STEP_W-1:0] n_q;
	logic              more_q;
	logic [7:0]        b0_q;
	logic [3:0]        semi_q;
	logic [4:0]        block_q;

	logic [7:0]  rdata;
	logic [15:0] ld16, ep16, ep1_16, s_maddr, rd16;
	logic [15:0] pbase, lbase;

	// song memory
	assign ld16   = {2'b00, address};
	assign ep16   = {1'b0, ep_q};
	assign ep1_16 = ep16 + 16'd1;

	always_comb begin
		case (cmd.rd_sel)
			RD_EP0:  rd16 = ep16;
			RD_EP1:  rd16 = ep1_16;
			RD_FLAG: rd16 = lbase + 16'd10;
			default: rd16 = s_maddr;
		endcase
	end

	fmes_ram #(.WIDTH(8), .DEPTH(SONG_BYTES)) u_song_ram (
		.clk   (clk),
		.we    (cmd.load),
		.waddr (ld16[AW-1:0]),
		.wdata (data),
		.raddr (rd16[AW-1:0]),
		.rdata (rdata)
	);

	// event decode from the fetched word
	logic [2:0]        d_op;
	logic [3:0]        d_ch;
	logic [7:0]        d_par;
	logic              d_chok;
	logic [PTR_W-1:0]  ep_adv, ep_fin;
	logic              d_more;
	logic [STEP_W-1:0] d_n;
	logic [2:0]        d_seq;
	logic [15:0]       d_prod;
	logic [4:0]        d_q;
	logic [7:0]        d_rem;

	assign d_op   = b0_q[2:0];
	assign d_ch   = b0_q[7:4];
	assign d_par  = rdata;
	assign d_chok = (d_ch < 4'(CHANNELS));
	assign ep_adv = ep_q + PTR_W'(2);
	assign ep_fin = (d_op == OP_JUMP) ? lp_q : ep_adv;
	assign d_more = (d_op != OP_DELAY) && (({1'b0, ep_fin} + 16'd1) < {1'b0, slen_q});
	// note split into octave and semitone: divide by 12 as multiply by 171 / 2048
	assign d_prod = {8'd0, d_par} * 16'd171;
	assign d_q    = d_prod[15:11];
	assign d_rem  = d_par - ({3'd0, d_q} * 8'd12);

	always_comb begin
		d_seq = SEQ_NONE;
		d_n   = '0;
		if (d_chok) begin
			case (d_op)
				OP_PATCH: begin
					d_seq = SEQ_PATCH;
					d_n = 5'd6 + ((car_slot(d_ch) != NOSLOT) ? 5'd5 : 5'd0)
						+ ((fb_index(d_ch) != NOSLOT) ? 5'd1 : 5'd0);
				end
				OP_NOTE: begin
					d_seq = SEQ_NOTE;
					d_n = (d_ch < 4'd6) ? 5'd3 : ((d_ch == 4'd6) ? 5'd4 : 5'd2);
				end
				OP_KEYOFF: begin
					d_seq = SEQ_KEYOFF;
					d_n = 5'd1;
				end
				OP_LEVEL: begin
					d_seq = SEQ_LEVEL;
					d_n = 5'd1;
				end
				default: begin
					d_seq = SEQ_NONE;
					d_n = '0;
				end
			endcase
		end
	end

	// per-step register write
	logic [STEP_W-1:0] k, km1;
	logic [2:0]        sil_ch;
	logic [3:0]        shamt;
	logic [7:0]        rbit, off_addr, off_val;
	logic              off_rw, has_car, single;
	logic [7:0]        ci_cur, hi, slot;
	logic [4:0]        vol;
	logic [7:0]        s_addr, s_val, s_rval;
	logic              s_mem, s_rwe;

	assign k        = cmd.step;
	assign km1      = k - 5'd1;
	assign sil_ch   = 3'(5'd29 - k);
	assign shamt    = ch_q - 4'd6;
	assign rbit     = RHY_TOP_BIT >> shamt[2:0];
	assign off_rw   = (ch_q >= 4'd6);
	assign off_addr = off_rw ? RHYTHM_REG : KEY_BASE + {4'd0, ch_q};
	assign off_val  = off_rw ? (rhythm_q & ~rbit) : 8'h00;
	assign has_car  = (car_slot(ch_q) != NOSLOT);
	assign single   = !has_car;
	assign ci_cur   = ci_q[ch_q];
	assign pbase    = {4'd0, param_q, 4'd0};
	assign lbase    = {4'd0, ci_cur, 4'd0};
	assign vol      = (param_q > 8'd30) ? 5'd30 : param_q[4:0];
	assign slot     = single ? mod_slot(ch_q) : car_slot(ch_q);
	assign hi       = {1'b0, block_q, 2'b00} | ((semi_q >= 4'd7) ? 8'h01 : 8'h00)
		| ((ch_q < 4'd6) ? KEYON_BIT : 8'h00);

	always_comb begin
		s_addr  = '0;
		s_val   = '0;
		s_mem   = 1'b0;
		s_maddr = '0;
		s_rwe   = 1'b0;
		s_rval  = rhythm_q;
		case (seq_q)
			SEQ_SILENCE: begin
				if (k < 5'd22) begin
					s_addr = LEVEL_BASE + {3'd0, k};
					s_val  = ATTEN_MAX;
				end else if (k < 5'd24) begin
					s_addr = RHYTHM_REG;
					s_val  = RHYTHM_INIT;
				end else begin
					s_addr = KEY_BASE + {5'd0, sil_ch};
				end
			end
			SEQ_PATCH: begin
				if (k == '0) begin
					s_addr = off_addr;
					s_val  = off_val;
					s_rwe  = off_rw;
					s_rval = off_val;
				end else if (k <= 5'd5 || (has_car && k <= 5'd10)) begin
					s_mem   = 1'b1;
					s_maddr = pbase + {11'd0, km1};
					s_val   = rdata;
					s_addr  = ((k <= 5'd5) ? mod_slot(ch_q) : car_slot(ch_q))
						+ grp_base(km1[3:0]);
				end else begin
					s_mem   = 1'b1;
					s_maddr = pbase + 16'd10;
					s_val   = rdata;
					s_addr  = FB_BASE + fb_index(ch_q);
				end
			end
			SEQ_NOTE: begin
				if (k == '0) begin
					s_addr = off_addr;
					s_val  = off_val;
					s_rwe  = off_rw;
					s_rval = off_val;
				end else if (ch_q <= 4'd6 && k == 5'd1) begin
					s_addr = FNUM_BASE + {4'd0, ch_q};
					s_val  = freq_low(semi_q);
				end else if (ch_q <= 4'd6 && k == 5'd2) begin
					s_addr = KEY_BASE + {4'd0, ch_q};
					s_val  = hi;
				end else begin
					s_addr = RHYTHM_REG;
					s_val  = rhythm_q | rbit;
					s_rwe  = 1'b1;
					s_rval = rhythm_q | rbit;
				end
			end
			SEQ_KEYOFF: begin
				s_addr = off_addr;
				s_val  = off_val;
				s_rwe  = off_rw;
				s_rval = off_val;
			end
			SEQ_LEVEL: begin
				s_mem = 1'b1;
				s_val = scaled(rdata, vol);
				if (k == '0) begin
					s_maddr = lbase + (single ? 16'd1 : 16'd6);
					s_addr  = LEVEL_BASE + slot;
				end else begin
					s_maddr = lbase + 16'd1;
					s_addr  = LEVEL_BASE + mod_slot(ch_q);
				end
			end
			default: begin
				s_addr = '0;
			end
		endcase
	end

	// status to the controller
	always_comb begin
		sts.playing    = playing_q;
		sts.delay_zero = (delay_q == '0);
		sts.ep_ok      = (ep1_16 < {1'b0, slen_q});
		sts.seq_level  = (seq_q == SEQ_LEVEL);
		sts.n_zero     = (n_q == '0);
		sts.step_mem   = s_mem;
		sts.out_free   = !out_valid || out_ready;
		sts.n          = n_q;
	end

	// sequencer state and configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			icount_q  <= '0;
			slen_q    <= '0;
			ep_q      <= '0;
			lp_q      <= '0;
			delay_q   <= '0;
			rhythm_q  <= RHYTHM_INIT;
			playing_q <= 1'b0;
			seq_q     <= SEQ_NONE;
			n_q       <= '0;
			more_q    <= 1'b0;
			for (int i = 0; i < CHANNELS; i++) begin
				ci_q[i] <= '0;
			end
		end else begin
			if (cfg_we) begin
				if (cfg_index == CFG_INSTR_COUNT) begin
					icount_q <= cfg_data[9:0];
				end else begin
					slen_q <= cfg_data;
				end
			end
			if (cmd.take) begin
				more_q <= 1'b0;
			end
			if (cmd.start || cmd.stop) begin
				rhythm_q <= RHYTHM_INIT;
				seq_q    <= SEQ_SILENCE;
				n_q      <= SILENCE_WRITES;
				playing_q <= cmd.start;
			end
			if (cmd.start) begin
				ep_q    <= {1'b0, icount_q, 4'd0};
				lp_q    <= {1'b0, icount_q, 4'd0};
				delay_q <= '0;
			end
			if (cmd.dly_dec) begin
				delay_q <= delay_q - 8'd1;
			end
			if (cmd.decode) begin
				ep_q   <= ep_fin;
				seq_q  <= d_seq;
				n_q    <= d_n;
				more_q <= d_more;
				if (d_op == OP_MARK) begin
					lp_q <= ep_adv;
				end
				if (d_op == OP_DELAY) begin
					delay_q <= d_par;
				end
				if (d_op == OP_PATCH && d_chok) begin
					ci_q[d_ch] <= d_par;
				end
			end
			// second level write when the patch uses additive connection
			if (cmd.cap_flag && rdata[0] && has_car) begin
				n_q <= 5'd2;
			end
			if (cmd.emit && s_rwe) begin
				rhythm_q <= s_rval;
			end
		end
	end

	// fetched event fields
	always_ff @(posedge clk) begin
		if (cmd.cap0) begin
			b0_q <= rdata;
		end
		if (cmd.decode) begin
			ch_q    <= d_ch;
			param_q <= d_par;
			semi_q  <= d_rem[3:0];
			block_q <= d_q + 5'd2;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (cmd.emit || cmd.emit_empty) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			write_valid <= 1'b1;
			reg_addr    <= s_addr;
			reg_value   <= s_val;
			more        <= more_q;
			last        <= cmd.last;
		end else if (cmd.emit_empty) begin
			write_valid <= 1'b0;
			reg_addr    <= '0;
			reg_value   <= '0;
			more        <= more_q;
			last        <= 1'b1;
		end
	end

endmodule
`default_nettype wire

>>> rtl/core/fmes_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module fmes_ctrl import fmes_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [2:0] action,
	input  wire fmes_sts_t  sts,
	output fmes_cmd_t       cmd
);

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_RD0   = 4'd1;
	localparam logic [3:0] ST_RD1   = 4'd2;
	localparam logic [3:0] ST_RD2   = 4'd3;
	localparam logic [3:0] ST_DISP  = 4'd4;
	localparam logic [3:0] ST_PRE   = 4'd5;
	localparam logic [3:0] ST_PRE2  = 4'd6;
	localparam logic [3:0] ST_EMIT  = 4'd7;
	localparam logic [3:0] ST_EMPTY = 4'd8;

	logic [3:0]        state_q, state_d;
	logic [STEP_W-1:0] step_q, step_d;
	logic              dok_q, dok_d;
	logic              acc, is_last;

	assign in_ready = (state_q == ST_IDLE);
	assign acc      = in_valid && in_ready;
	assign is_last  = ((step_q + 5'd1) == sts.n);

	// next state and commands
	always_comb begin
		state_d    = state_q;
		step_d     = step_q;
		dok_d      = dok_q;
		cmd        = '0;
		cmd.step   = step_q;
		cmd.rd_sel = RD_STEP;
		case (state_q)
			ST_IDLE: begin
				step_d = '0;
				dok_d  = 1'b0;
				if (acc) begin
					cmd.take = 1'b1;
					case (action)
						ACT_LOAD: cmd.load = 1'b1;
						ACT_START: begin
							cmd.start = 1'b1;
							state_d = ST_EMIT;
						end
						ACT_STOP: begin
							cmd.stop = 1'b1;
							state_d = ST_EMIT;
						end
						ACT_TICK: begin
							if (!sts.playing) begin
								state_d = ST_EMPTY;
							end else if (!sts.delay_zero) begin
								cmd.dly_dec = 1'b1;
								state_d = ST_EMPTY;
							end else begin
								state_d = ST_RD0;
							end
						end
						ACT_CONT: begin
							state_d = (sts.playing && sts.delay_zero) ? ST_RD0 : ST_EMPTY;
						end
						default: state_d = ST_IDLE;
					endcase
				end
			end
			ST_RD0: begin
				cmd.rd_sel = RD_EP0;
				state_d = sts.ep_ok ? ST_RD1 : ST_EMPTY;
			end
			ST_RD1: begin
				cmd.rd_sel = RD_EP1;
				cmd.cap0 = 1'b1;
				state_d = ST_RD2;
			end
			ST_RD2: begin
				cmd.decode = 1'b1;
				state_d = ST_DISP;
			end
			ST_DISP: begin
				if (sts.seq_level) begin
					state_d = ST_PRE;
				end else if (sts.n_zero) begin
					state_d = ST_EMPTY;
				end else begin
					state_d = ST_EMIT;
				end
			end
			ST_PRE: begin
				cmd.rd_sel = RD_FLAG;
				state_d = ST_PRE2;
			end
			ST_PRE2: begin
				cmd.cap_flag = 1'b1;
				state_d = ST_EMIT;
			end
			ST_EMIT: begin
				// a step that reads the song memory first waits for its registered byte
				if (sts.out_free && (!sts.step_mem || dok_q)) begin
					cmd.emit = 1'b1;
					cmd.last = is_last;
					step_d = step_q + 5'd1;
					dok_d = 1'b0;
					if (is_last) begin
						state_d = ST_IDLE;
					end
				end else if (sts.step_mem) begin
					dok_d = 1'b1;
				end
			end
			ST_EMPTY: begin
				if (sts.out_free) begin
					cmd.emit_empty = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
			dok_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			step_q  <= step_d;
			dok_q   <= dok_d;
		end
	end

endmodule
`default_nettype wire

>>> rtl/core/fm_music_event_sequencer.sv
`timescale 1ns / 1ps
`default_nettype none
// FM music event sequencer: turns a song held in an internal byte memory into
// FM chip register writes.
// Input channel (in_valid/in_ready): one item carries action, address, data.
// A load item writes one song byte and gives no result. Start and stop give 30
// results, tick and continue give one or more; the final result has last set,
// and more set on every result of a tick asks for a continue item.
// Output channel (out_valid/out_ready): one register write (or an empty
// result) per transfer, held in a result register until taken.
// Configuration: cfg_we writes instrument_count (index 0) or song_length
// (index 1) from cfg_data; write only while the block is idle.
// Flow: the block handles one input item at a time. Start and stop emit one
// result per cycle while the result register is free. An event decode reads
// the event word through the single read port of the song memory (states
// RD0 to RD2, plus PRE and PRE2 for a level event), then emits its writes; a
// write whose value comes from the song memory first waits for its byte.
// A load leaves the block ready for the next item. When the receiver stalls,
// the sequencer holds at the current write and resumes once the result
// register is taken. Reset clears all playback state; the song memory is not
// cleared and needs loading before use.
module fm_music_event_sequencer import fmes_pkg::*; #(
	parameter int SONG_BYTES = SONG_BYTES_DEF
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_ready,
	input  wire logic [2:0]       action,
	input  wire logic [13:0]      address,
	input  wire logic [7:0]       data,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output logic                  write_valid,
	output logic      [7:0]       reg_addr,
	output logic      [7:0]       reg_value,
	output logic                  more,
	output logic                  last,
	input  wire logic             cfg_we,
	input  wire logic             cfg_index,
	input  wire logic [CFG_W-1:0] cfg_data
);

	fmes_cmd_t cmd;
	fmes_sts_t sts;

	// sequencing control
	fmes_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.action   (action),
		.sts      (sts),
		.cmd      (cmd)
	);

	// song memory, playback state and result register
	fmes_datapath #(.SONG_BYTES(SONG_BYTES)) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.address     (address),
		.data        (data),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.out_ready   (out_ready),
		.out_valid   (out_valid),
		.write_valid (write_valid),
		.reg_addr    (reg_addr),
		.reg_value   (reg_value),
		.more        (more),
		.last        (last)
	);

endmodule
`default_nettype wire

>>> rtl/core/fmes_checker.sv
`timescale 1ns / 1ps
`default_nettype none
module fmes_checker import fmes_pkg::*; (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       in_valid,
	input wire logic       in_ready,
	input wire logic [2:0] action,
	input wire logic       out_valid,
	input wire logic       out_ready,
	input wire logic       write_valid,
	input wire logic [7:0] reg_addr,
	input wire logic [7:0] reg_value,
	input wire logic       last
);

	// a stalled result holds
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(reg_addr) && $stable(reg_value))
		else $error("stalled result changed");

	// only the final result of an item may be empty
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last |-> write_valid)
		else $error("empty result before the final one");

	// an empty result carries no write
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !write_valid |-> reg_addr == 8'h00 && reg_value == 8'h00 && last)
		else $error("empty result carries data");

	// start and stop keep the input closed while silencing
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (action == ACT_START || action == ACT_STOP) |=> !in_ready)
		else $error("input taken during silencing");

endmodule

bind fm_music_event_sequencer fmes_checker u_fmes_checker (.*);
`default_nettype wire

>>> test/fm_music_event_sequencer_test.sv
`timescale 1ns / 1ps
module fm_music_event_sequencer_test;
	import fmes_pkg::*;

	localparam int MEM_BYTES = 16384;
	localparam int TAIL_CYCLES = 60;

	typedef struct packed {
		logic       write_valid;
		logic [7:0] reg_addr;
		logic [7:0] reg_value;
		logic       more;
		logic       last;
	} chip_write_t;

	// song player prediction and the store of expected chip writes
	class chip_write_board;
		logic [7:0] song [0:MEM_BYTES-1];
		int unsigned instr_count, song_len, ev_ptr, loop_ptr;
		logic [7:0] delay_left, rhythm;
		logic [7:0] voice_patch [0:CHANNELS-1];
		bit playing, want_more;
		logic [7:0] mod_t [0:10], car_t [0:10], fb_t [0:10], att_t [0:30], flo_t [0:11];
		chip_write_t pending [$];
		chip_write_t item_writes [$];
		int writes_seen, items_seen;

		function new();
			mod_t = '{8'h00, 8'h01, 8'h02, 8'h08, 8'h09, 8'h0a, 8'h10, 8'h14, 8'h12, 8'h15, 8'h11};
			car_t = '{8'h03, 8'h04, 8'h05, 8'h0b, 8'h0c, 8'h0d, 8'h13, 8'hff, 8'hff, 8'hff, 8'hff};
			fb_t = '{8'h00, 8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'h06, 8'h07, 8'hff, 8'h08, 8'hff};
			att_t = '{8'h3f, 8'h14, 8'h10, 8'h0e, 8'h0c, 8'h0a, 8'h09, 8'h08, 8'h07, 8'h06, 8'h06,
				8'h05, 8'h05, 8'h04, 8'h04, 8'h04, 8'h04, 8'h04, 8'h03, 8'h03, 8'h03, 8'h03,
				8'h02, 8'h02, 8'h02, 8'h01, 8'h01, 8'h01, 8'h01, 8'h00, 8'h00};
			flo_t = '{8'hac, 8'hb6, 8'hc1, 8'hcd, 8'hd9, 8'he6, 8'hf3, 8'h02, 8'h11, 8'h22,
				8'h33, 8'h45};
			instr_count = 0;
			song_len = 0;
			ev_ptr = 0;
			loop_ptr = 0;
			delay_left = 0;
			rhythm = RHYTHM_INIT;
			for (int i = 0; i < CHANNELS; i++) voice_patch[i] = 0;
			playing = 0;
			want_more = 0;
			writes_seen = 0;
			items_seen = 0;
		endfunction

		function logic [7:0] rd(int unsigned a);
			return song[a % MEM_BYTES];
		endfunction

		function void put(logic [7:0] ra, logic [7:0] rv);
			chip_write_t w;
			if (item_writes.size() >= 30) return;
			w.write_valid = 1;
			w.reg_addr = ra;
			w.reg_value = rv;
			w.more = 0;
			w.last = 0;
			item_writes.push_back(w);
		endfunction

		function void close_item(bit m);
			chip_write_t w;
			if (item_writes.size() == 0) begin
				w = '0;
				item_writes.push_back(w);
			end
			item_writes[item_writes.size()-1].last = 1;
			foreach (item_writes[k]) begin
				item_writes[k].more = m;
				pending.push_back(item_writes[k]);
			end
			item_writes.delete();
			want_more = m;
		endfunction

		function void key_off(int unsigned ch);
			if (ch < 6) begin
				put(KEY_BASE + ch[7:0], 8'h00);
			end else begin
				rhythm = rhythm & ~(8'h10 >> (ch - 6));
				put(RHYTHM_REG, rhythm);
			end
		endfunction

		function void mute_all();
			rhythm = RHYTHM_INIT;
			for (int r = 'h40; r <= 'h55; r++) put(r[7:0], ATTEN_MAX);
			for (int ch = 7; ch >= 0; ch--) key_off(ch);
		endfunction

		function void patch(int unsigned ch, int unsigned n);
			logic [7:0] grp [0:4];
			int unsigned base;
			grp = '{8'h20, 8'h40, 8'h60, 8'h80, 8'he0};
			base = n * 16;
			key_off(ch);
			voice_patch[ch] = n[7:0];
			for (int b = 0; b < 5; b++) put(mod_t[ch] + grp[b], rd(base + b));
			if (car_t[ch] != 8'hff)
				for (int b = 5; b < 10; b++) put(car_t[ch] + grp[b-5], rd(base + b));
			if (fb_t[ch] != 8'hff) put(FB_BASE + fb_t[ch], rd(base + 10));
		endfunction

		function void note_on(int unsigned ch, int unsigned nt);
			int unsigned phys, blk, semi;
			logic [7:0] hi;
			key_off(ch);
			if (ch <= 6) begin
				phys = fb_t[ch];
				blk = nt / 12 + 2;
				semi = nt % 12;
				put(FNUM_BASE + phys[7:0], flo_t[semi]);
				hi = 8'(((semi >= 7) ? 1 : 0) | (blk << 2));
				if (phys < 6) hi = hi | KEYON_BIT;
				put(KEY_BASE + phys[7:0], hi);
				if (ch < 6) return;
			end
			rhythm = rhythm | (8'h10 >> (ch - 6));
			put(RHYTHM_REG, rhythm);
		endfunction

		function logic [7:0] attenuate(logic [7:0] v, int unsigned vol);
			int unsigned a;
			a = v[5:0] + att_t[vol];
			if (a > 'h3f) a = 'h3f;
			return {v[7:6], a[5:0]};
		endfunction

		function void level(int unsigned ch, int unsigned vol);
			int unsigned base;
			bit one_op;
			logic [7:0] conn;
			base = voice_patch[ch] * 16;
			one_op = (car_t[ch] == 8'hff);
			conn = rd(base + 10);
			if (vol > 30) vol = 30;
			put(LEVEL_BASE + (one_op ? mod_t[ch] : car_t[ch]),
				attenuate(rd(base + (one_op ? 1 : 6)), vol));
			if (!one_op && conn[0])
				put(LEVEL_BASE + mod_t[ch], attenuate(rd(base + 1), vol));
		endfunction

		function bit next_event();
			logic [15:0] w;
			int unsigned ch, p;
			if (ev_ptr + 1 >= song_len) return 0;
			w = {rd(ev_ptr + 1), rd(ev_ptr)};
			ev_ptr += 2;
			ch = w[7:4];
			p = w[15:8];
			case (w[2:0])
				OP_DELAY: begin
					delay_left = w[15:8];
					return 0;
				end
				OP_PATCH: if (ch < CHANNELS) patch(ch, p);
				OP_NOTE: if (ch < CHANNELS) note_on(ch, p);
				OP_KEYOFF: if (ch < CHANNELS) key_off(ch);
				OP_LEVEL: if (ch < CHANNELS) level(ch, p);
				OP_JUMP: ev_ptr = loop_ptr;
				OP_MARK: loop_ptr = ev_ptr;
				default: ;
			endcase
			return ev_ptr + 1 < song_len;
		endfunction

		// note an accepted input item
		function void take_item(logic [2:0] act, logic [13:0] addr, logic [7:0] dat);
			bit m;
			m = 0;
			items_seen++;
			case (act)
				ACT_LOAD: song[addr] = dat;
				ACT_START: begin
					mute_all();
					ev_ptr = instr_count * 16;
					loop_ptr = ev_ptr;
					delay_left = 0;
					playing = 1;
					close_item(0);
				end
				ACT_STOP: begin
					mute_all();
					playing = 0;
					close_item(0);
				end
				ACT_TICK: begin
					if (playing) begin
						if (delay_left != 0) delay_left--;
						else m = next_event();
					end
					close_item(m);
				end
				ACT_CONT: begin
					if (playing && delay_left == 0) m = next_event();
					close_item(m);
				end
				default: ;
			endcase
		endfunction

		// compare a result with the oldest expected write
		function bit check_write(chip_write_t got, output string why);
			chip_write_t e;
			writes_seen++;
			if (pending.size() == 0) begin
				why = $sformatf("unexpected result %p", got);
				return 0;
			end
			e = pending.pop_front();
			why = "";
			if (got.write_valid !== e.write_valid) why = {why, " write_valid"};
			if (got.reg_addr !== e.reg_addr) why = {why, " reg_addr"};
			if (got.reg_value !== e.reg_value) why = {why, " reg_value"};
			if (got.more !== e.more) why = {why, " more"};
			if (got.last !== e.last) why = {why, " last"};
			if (why != "") begin
				why = $sformatf("wrong%s: got %p expected %p", why, got, e);
				return 0;
			end
			return 1;
		endfunction
	endclass

	logic clk, arst_n;
	logic in_valid, in_ready;
	logic [2:0] action;
	logic [13:0] address;
	logic [7:0] data;
	logic out_valid, out_ready;
	logic write_valid, more, last;
	logic [7:0] reg_addr, reg_value;
	logic cfg_we, cfg_index;
	logic [CFG_W-1:0] cfg_data;

	chip_write_board board;
	int errors;
	int idle_pct, stall_pct;
	bit hold_req;
	int hold_left;

	fm_music_event_sequencer dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.action(action), .address(address), .data(data),
		.out_valid(out_valid), .out_ready(out_ready),
		.write_valid(write_valid), .reg_addr(reg_addr), .reg_value(reg_value),
		.more(more), .last(last),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	initial clk = 0;
	always #5 clk = ~clk;

	task report(string msg);
		$display("tb: mismatch at %0t: %s", $realtime, msg);
		errors++;
	endtask

	// receiver: random stalls plus an occasional long hold-off
	always @(negedge clk) begin
		if (hold_req && hold_left == 0) hold_left = 400;
		if (hold_left > 0) begin
			hold_left--;
			if (hold_left == 0) hold_req = 0;
			out_ready <= 0;
		end else begin
			out_ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	// result checking
	always @(posedge clk) begin
		chip_write_t got;
		string why;
		if (arst_n && out_valid && out_ready) begin
			got = '{write_valid, reg_addr, reg_value, more, last};
			if (!board.check_write(got, why)) report(why);
		end
	end

	task send_item(logic [2:0] act, logic [13:0] addr, logic [7:0] dat);
		while ($urandom_range(99) < idle_pct) begin
			@(negedge clk);
			in_valid <= 0;
		end
		@(negedge clk);
		in_valid <= 1;
		action <= act;
		address <= addr;
		data <= dat;
		do @(posedge clk); while (!in_ready);
		board.take_item(act, addr, dat);
	endtask

	task drain();
		@(negedge clk);
		in_valid <= 0;
		while (board.pending.size() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
	endtask

	task write_cfg(logic idx, int unsigned val);
		@(negedge clk);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= val[CFG_W-1:0];
		@(negedge clk);
		cfg_we <= 0;
		if (idx == CFG_INSTR_COUNT) board.instr_count = val;
		else board.song_len = val;
	endtask

	function logic [15:0] rand_event();
		logic [2:0] op;
		logic [3:0] ch;
		logic [7:0] p;
		op = 3'($urandom_range(7));
		ch = ($urandom_range(9) < 8) ? 4'($urandom_range(10)) : 4'($urandom_range(15, 11));
		p = 8'($urandom_range(255));
		if (op == OP_DELAY) p = 8'($urandom_range(3));
		if (op == OP_PATCH) p = 8'($urandom_range(7));
		return {p, ch, 1'b0, op};
	endfunction

	// configure, fill the event area and play it; optionally hold the receiver midway
	task play_phase(int unsigned ic, int unsigned sl, int steps, logic [15:0] evs [$],
		bit hold);
		int unsigned a0;
		int r;
		logic [15:0] w;
		drain();
		write_cfg(CFG_INSTR_COUNT, ic);
		write_cfg(CFG_SONG_LEN, sl);
		a0 = ic * 16;
		for (int unsigned a = a0; a < sl; a += 2) begin
			w = (evs.size() != 0) ? evs.pop_front() : rand_event();
			send_item(ACT_LOAD, a[13:0], w[7:0]);
			if (a + 1 < sl) send_item(ACT_LOAD, a[13:0] + 14'd1, w[15:8]);
		end
		send_item(ACT_START, 14'($urandom), 8'($urandom));
		for (int s = 0; s < steps; s++) begin
			if (hold && s == steps / 2) hold_req = 1;
			r = $urandom_range(99);
			if (board.want_more && r < 85) send_item(ACT_CONT, 14'($urandom), 8'($urandom));
			else if (r < 3) send_item(ACT_STOP, 14'($urandom), 8'($urandom));
			else if (r < 5)
				send_item(3'($urandom_range(7, 5)), 14'($urandom), 8'($urandom));
			else if (r < 8) send_item(ACT_CONT, 14'($urandom), 8'($urandom));
			else if (r < 10) send_item(ACT_LOAD, 14'($urandom), 8'($urandom));
			else if (r < 11) send_item(ACT_START, 14'($urandom), 8'($urandom));
			else send_item(ACT_TICK, 14'($urandom), 8'($urandom));
		end
		send_item(ACT_STOP, 14'($urandom), 8'($urandom));
	endtask

	initial begin
		logic [15:0] evs [$];
		board = new();
		errors = 0;
		idle_pct = 0;
		stall_pct = 0;
		hold_req = 0;
		hold_left = 0;
		in_valid = 0;
		action = ACT_LOAD;
		address = 0;
		data = 0;
		out_ready = 0;
		cfg_we = 0;
		cfg_index = CFG_INSTR_COUNT;
		cfg_data = 0;
		arst_n = 0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// instrument records 0 to 7, extremes of data and address
		for (int a = 0; a < 128; a++)
			send_item(ACT_LOAD, 14'(a), (a == 3) ? 8'hff : (a == 4) ? 8'h00 : 8'($urandom));
		send_item(ACT_LOAD, 14'h3fff, 8'hff);
		send_item(ACT_LOAD, 14'h2aaa, 8'h55);

		// empty song: start, tick, continue, stop, unknown actions
		drain();
		write_cfg(CFG_INSTR_COUNT, 0);
		write_cfg(CFG_SONG_LEN, 0);
		send_item(ACT_TICK, 0, 0);
		send_item(ACT_START, 14'h3fff, 8'hff);
		send_item(ACT_TICK, 0, 0);
		send_item(ACT_CONT, 0, 0);
		send_item(3'd5, 0, 0);
		send_item(3'd6, 0, 0);
		send_item(3'd7, 0, 0);
		send_item(ACT_STOP, 0, 0);

		// directed events: every opcode, channel groups, clamps, ignored channels
		evs = '{16'h0301, 16'h0561, 16'h0271, 16'h0681, 16'h0002, 16'hff62, 16'h3092,
			16'h2ea2, 16'h0033, 16'h0083, 16'h0004, 16'hc824, 16'h1fa4, 16'h5564,
			16'h30c2, 16'h05f1, 16'h0006, 16'h0007, 16'h0200, 16'h4012, 16'h0005,
			16'h00b3, 16'h0000};
		play_phase(8, 128 + 2 * 23, 30, evs, 0);

		// random songs under different flow patterns
		idle_pct = 62;
		stall_pct = 0;
		evs.delete();
		play_phase(2, 32 + 2 * 12 + 1, 12, evs, 0);

		idle_pct = 0;
		stall_pct = 62;
		play_phase(5, 80 + 2 * 10, 12, evs, 1);

		idle_pct = 30;
		stall_pct = 30;
		play_phase(1023, MEM_BYTES, 10, evs, 0);

		drain();
		$display("tb: %0d input items accepted, %0d chip writes checked", board.items_seen,
			board.writes_seen);
		$display("tb: covered loads, start/stop, ticks, continues and all event kinds");
		if (errors == 0) $display("tb: success");
		else $display("tb: failure");
		$finish;
	end

	initial begin
		#20ms;
		$display("tb: failure");
		$finish;
	end
endmodule

>>> fm_music_event_sequencer.f
rtl/core/fmes_pkg.sv
rtl/core/fmes_ram.sv
rtl/core/fmes_datapath.sv
rtl/core/fmes_ctrl.sv
rtl/core/fm_music_event_sequencer.sv
rtl/core/fmes_checker.sv
test/fm_music_event_sequencer_test.sv
